@@ rtl/prt_pkg.sv @@
// Shared types and constants for the protected range table.
package prt_pkg;

  localparam int MAX_RANGES = 64;
  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINAL  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic ins_shift;
    logic ins_place;
    logic srch_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       add_reject;
    logic       shift_ok;
    logic       lookup_skip;
    logic       srch_hit;
    logic       srch_last;
  } dp_stat_t;

endpackage

@@ rtl/prt_dp.sv @@
// Datapath: range store, counters, add checks, insertion shifter and search window.
module prt_dp #(
  parameter int MaxRanges = prt_pkg::MAX_RANGES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prt_pkg::ctrl_cmd_t            cmd_i,
  output prt_pkg::dp_stat_t             stat_o,
  input  logic [1:0]                    op_i,
  input  logic [prt_pkg::ADDR_W-1:0]    region_base_i,
  input  logic [prt_pkg::ADDR_W-1:0]    region_size_i,
  input  logic [prt_pkg::ADDR_W-1:0]    query_address_i,
  output logic [1:0]                    status_o,
  output logic                          is_protected_o
);

  localparam int AW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int CW = $clog2(MaxRanges + 1);
  localparam int PW = prt_pkg::PAGE_W;
  localparam int PS = prt_pkg::PAGE_SHIFT;
  localparam int XW = prt_pkg::ADDR_W;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxRanges);

  // range store
  logic [PW-1:0] start_mem [MaxRanges];
  logic [PW-1:0] end_mem   [MaxRanges];
  logic [PW-1:0] rd_start_q, rd_end_q;

  // control state
  logic [CW-1:0] count_q, search_cnt_q;
  logic          frozen_q;
  logic [PW-1:0] high_end_q;

  // working registers
  logic [1:0]    op_q;
  logic [XW-1:0] end_q;
  logic          carry_q, size_zero_q;
  logic [PW-1:0] spg_q, epg_q, pg_q;
  logic [CW-1:0] idx_q, lo_q, hi_q;
  logic [1:0]    res_status_q, out_status_q;
  logic          res_hit_q, out_hit_q;

  logic          end_low_nz, add_invalid, full;
  logic [PW-1:0] epg_d;
  logic [CW-1:0] idx_m1, mid, mid_p1;
  logic          go_left, go_right;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [PW-1:0] wr_start, wr_end;
  logic          we;

  // add checks: zero size, 64-bit wrap, round-up past the top page
  assign end_low_nz  = |end_q[PS-1:0];
  assign add_invalid = size_zero_q | carry_q | (end_low_nz & (&end_q[XW-1:PS]));
  assign full        = (count_q == MaxCnt);
  assign epg_d       = end_q[XW-1:PS] + PW'(end_low_nz);

  // search window is [lo, hi)
  assign mid      = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);
  assign mid_p1   = mid + CW'(1);
  assign idx_m1   = idx_q - CW'(1);
  assign go_left  = (pg_q < rd_start_q);
  assign go_right = (pg_q >= rd_end_q);

  assign rd_addr  = (op_q == prt_pkg::OP_LOOKUP) ? mid[AW-1:0] : idx_m1[AW-1:0];
  assign wr_addr  = idx_q[AW-1:0];
  assign we       = cmd_i.ins_shift | cmd_i.ins_place;
  assign wr_start = cmd_i.ins_shift ? rd_start_q : spg_q;
  assign wr_end   = cmd_i.ins_shift ? rd_end_q : epg_q;

  assign stat_o.op          = op_q;
  assign stat_o.add_reject  = add_invalid | full;
  assign stat_o.shift_ok    = !frozen_q && (idx_q != '0) && (rd_start_q > spg_q);
  assign stat_o.lookup_skip = !frozen_q || (search_cnt_q == '0) || (pg_q >= high_end_q);
  assign stat_o.srch_hit    = !go_left && !go_right;
  assign stat_o.srch_last   = go_left ? (lo_q >= mid) : (mid_p1 >= hi_q);

  assign status_o       = out_status_q;
  assign is_protected_o = out_hit_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
    rd_start_q <= start_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      search_cnt_q <= '0;
      frozen_q     <= 1'b0;
      high_end_q   <= '0;
    end else begin
      // freezing keeps high_end: before finalize it already is the max end
      if (cmd_i.eval && (op_q == prt_pkg::OP_FINAL) && !frozen_q) begin
        frozen_q     <= 1'b1;
        search_cnt_q <= count_q;
      end
      if (cmd_i.ins_place) begin
        count_q <= count_q + CW'(1);
        if (epg_q > high_end_q) begin
          high_end_q <= epg_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q              <= op_i;
      {carry_q, end_q}  <= {1'b0, region_base_i} + {1'b0, region_size_i};
      size_zero_q       <= (region_size_i == '0);
      spg_q             <= region_base_i[XW-1:PS];
      pg_q              <= query_address_i[XW-1:PS];
    end
    if (cmd_i.eval) begin
      epg_q     <= epg_d;
      idx_q     <= count_q;
      lo_q      <= '0;
      hi_q      <= search_cnt_q;
      res_hit_q <= 1'b0;
      if (op_q == prt_pkg::OP_ADD) begin
        res_status_q <= add_invalid ? prt_pkg::ST_INVALID :
                        full        ? prt_pkg::ST_FULL    : prt_pkg::ST_OK;
      end else begin
        res_status_q <= prt_pkg::ST_OK;
      end
    end
    if (cmd_i.ins_shift) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.srch_step) begin
      if (go_left) begin
        hi_q <= mid;
      end else if (go_right) begin
        lo_q <= mid_p1;
      end else begin
        res_hit_q <= 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
    end
  end

endmodule

@@ rtl/prt_ctrl.sv @@
// Controller: sequences each request through the datapath and owns the handshakes.
module prt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prt_pkg::ctrl_cmd_t  cmd_o,
  input  prt_pkg::dp_stat_t   stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_INS_RD,
    S_INS_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == S_EVAL);
    cmd_o.ins_shift = (state_q == S_INS_CMP) && stat_i.shift_ok;
    cmd_o.ins_place = (state_q == S_INS_CMP) && !stat_i.shift_ok;
    cmd_o.srch_step = (state_q == S_SRCH_CMP);
    cmd_o.load_out  = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a finishing request refills the output register on the same edge
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (stat_i.op)
            prt_pkg::OP_ADD: begin
              state_q <= stat_i.add_reject ? S_FINISH : S_INS_RD;
            end
            prt_pkg::OP_LOOKUP: begin
              state_q <= stat_i.lookup_skip ? S_FINISH : S_SRCH_RD;
            end
            default: begin
              state_q <= S_FINISH;
            end
          endcase
        end
        S_INS_RD: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          state_q <= stat_i.shift_ok ? S_INS_RD : S_FINISH;
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          state_q <= (stat_i.srch_hit || stat_i.srch_last) ? S_FINISH : S_SRCH_RD;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/protected_range_table.sv @@
// Top level of the protected range table: controller plus datapath.
//
//  channel | handshake                | payload
//  in      | in_valid_i, in_ready_o   | cmd_i, region_base_i, region_size_i, query_address_i
//  out     | out_valid_o, out_ready_i | status_o, is_protected_o
//
// One request at a time: accept, evaluate, result, with a read and a compare state per store read.
// Add: one store read per held entry starting above the new one (none once frozen), plus one;
//   rejected adds, finalize and the unused code go straight to the result.
// Lookup: p <= floor(log2(n))+1 probes over n frozen entries (7 for 64), one store
//   read each; lookups screened out go straight to the result.
// Reset clears counts, frozen flag and highest end; the store is never cleared.
// A request is taken while a result waits; it stalls in its last cycle until taken.
//
// Store layout: entries [0, searchable) are sorted by start page and frozen at
// finalize; adds after finalize append past them and only raise the highest end.
module protected_range_table #(
  parameter int MaxRanges = prt_pkg::MAX_RANGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [prt_pkg::ADDR_W-1:0] region_base_i,
  input  logic [prt_pkg::ADDR_W-1:0] region_size_i,
  input  logic [prt_pkg::ADDR_W-1:0] query_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic                       is_protected_o
);

  prt_pkg::ctrl_cmd_t cmd;
  prt_pkg::dp_stat_t  stat;

  // sequencing: handshakes, insert shift loop, search loop
  prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // store, counters, range checks, compare logic, output register
  prt_dp #(
    .MaxRanges (MaxRanges)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (cmd_i),
    .region_base_i   (region_base_i),
    .region_size_i   (region_size_i),
    .query_address_i (query_address_i),
    .status_o        (status_o),
    .is_protected_o  (is_protected_o)
  );

endmodule
